### rtl/core/sist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sist_pkg
// Shared types and codes for the sorted interval set table.
// ----------------------------------------------------------------------------
package sist_pkg;

    // command codes carried in s_tuser
    typedef enum logic [1:0] {
        CMD_ADD        = 2'd0,
        CMD_REMOVE     = 2'd1,
        CMD_INTERSECTS = 2'd2,
        CMD_CONTAINS   = 2'd3
    } cmd_t;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // one stored half-open interval [start, stop)
    typedef struct packed {
        logic [31:0] stop;
        logic [31:0] start;
    } entry_t;

    // finished result handed from the sequencer to the output stage
    typedef struct packed {
        logic [6:0] entries_used;
        logic [1:0] status;
        logic       answer;
    } result_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_PREV,
        ST_PREV_W,
        ST_NEXT,
        ST_NEXT_W,
        ST_DECIDE,
        ST_ABS,
        ST_ABS_CMP,
        ST_AFIX,
        ST_RSCAN,
        ST_RSCAN_CMP,
        ST_COMP,
        ST_COMP_W,
        ST_FIXPREV,
        ST_SHUP,
        ST_SHUP_W,
        ST_FINISH
    } state_t;

endpackage

### rtl/core/sist_table_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sist_table_mem
// Interval storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module sist_table_mem #(
    parameter int TABLE_CAPACITY = 64
) (
    input  logic                              aclk,
    input  logic                              wr_en,
    input  logic [$clog2(TABLE_CAPACITY)-1:0] wr_addr,
    input  sist_pkg::entry_t                  wr_data,
    input  logic                              rd_en,
    input  logic [$clog2(TABLE_CAPACITY)-1:0] rd_addr,
    output sist_pkg::entry_t                  rd_data
);

    sist_pkg::entry_t mem [TABLE_CAPACITY];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/sist_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sist_seq
// Sequencer: binary search, neighbour look-up, merge/drop scan, compaction
// and insertion shift over the interval store, one memory access per step.
// ----------------------------------------------------------------------------
module sist_seq #(
    parameter int TABLE_CAPACITY = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // command side
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sist_pkg::cmd_t                    in_cmd,
    input  logic [31:0]                       in_start,
    input  logic [31:0]                       in_end,
    // result side
    output logic                              res_valid,
    input  logic                              res_ready,
    output sist_pkg::result_t                 res,
    // memory side
    output logic                              wr_en,
    output logic [$clog2(TABLE_CAPACITY)-1:0] wr_addr,
    output sist_pkg::entry_t                  wr_data,
    output logic                              rd_en,
    output logic [$clog2(TABLE_CAPACITY)-1:0] rd_addr,
    input  sist_pkg::entry_t                  rd_data
);

    localparam int IW = $clog2(TABLE_CAPACITY);
    localparam int CW = $clog2(TABLE_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(TABLE_CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    sist_pkg::state_t state_reg, state_next;
    sist_pkg::cmd_t   cmd_reg, cmd_next;
    logic [31:0]      s_reg, s_next, e_reg, e_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0]    mid_reg, mid_next;
    logic [CW-1:0]    p_reg, p_next, pos_reg, pos_next;
    logic [CW-1:0]    j_reg, j_next, src_reg, src_next, dst_reg, dst_next;
    sist_pkg::entry_t prev_reg, prev_next, nxt_reg, nxt_next, ins_reg, ins_next;
    logic             has_prev_reg, has_prev_next, has_next_reg, has_next_next;
    logic             fix_reg, fix_next;
    logic [31:0]      nstart_reg, nstart_next, top_reg, top_next;
    logic             answer_reg, answer_next;
    logic [1:0]       status_reg, status_next;

    logic [CW:0]      mid_sum;
    logic             add_left, add_right, rem_full, prev_cut, comp_done;

    // shared decisions
    always_comb begin
        mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
        add_left  = has_prev_reg && (prev_reg.stop >= s_reg);
        add_right = has_next_reg && (nxt_reg.start <= e_reg);
        rem_full  = has_prev_reg && (s_reg < prev_reg.stop) && (e_reg < prev_reg.stop)
                    && (count_reg >= CAP);
        prev_cut  = has_prev_reg && (s_reg < prev_reg.stop);
        comp_done = (src_reg == dst_reg) || (src_reg >= count_reg);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sist_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        s_reg        <= s_next;
        e_reg        <= e_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        p_reg        <= p_next;
        pos_reg      <= pos_next;
        j_reg        <= j_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        ins_reg      <= ins_next;
        has_prev_reg <= has_prev_next;
        has_next_reg <= has_next_next;
        fix_reg      <= fix_next;
        nstart_reg   <= nstart_next;
        top_reg      <= top_next;
        answer_reg   <= answer_next;
        status_reg   <= status_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sist_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = (in_end > in_start) ? sist_pkg::ST_SRCH
                                                     : sist_pkg::ST_FINISH;
                end
            end
            sist_pkg::ST_SRCH:
                state_next = (lo_reg < hi_reg) ? sist_pkg::ST_SRCH_CMP : sist_pkg::ST_PREV;
            sist_pkg::ST_SRCH_CMP: state_next = sist_pkg::ST_SRCH;
            sist_pkg::ST_PREV:
                state_next = (p_reg != '0) ? sist_pkg::ST_PREV_W : sist_pkg::ST_NEXT;
            sist_pkg::ST_PREV_W: state_next = sist_pkg::ST_NEXT;
            sist_pkg::ST_NEXT:
                state_next = (p_reg < count_reg) ? sist_pkg::ST_NEXT_W : sist_pkg::ST_DECIDE;
            sist_pkg::ST_NEXT_W: state_next = sist_pkg::ST_DECIDE;
            sist_pkg::ST_DECIDE: begin
                case (cmd_reg)
                    sist_pkg::CMD_ADD: begin
                        if (add_left || add_right) begin
                            state_next = sist_pkg::ST_ABS;
                        end else if (count_reg >= CAP) begin
                            state_next = sist_pkg::ST_FINISH;
                        end else begin
                            state_next = sist_pkg::ST_SHUP;
                        end
                    end
                    sist_pkg::CMD_REMOVE:
                        state_next = rem_full ? sist_pkg::ST_FINISH : sist_pkg::ST_RSCAN;
                    default: state_next = sist_pkg::ST_FINISH;
                endcase
            end
            sist_pkg::ST_ABS:
                state_next = (j_reg < count_reg) ? sist_pkg::ST_ABS_CMP : sist_pkg::ST_AFIX;
            sist_pkg::ST_ABS_CMP:
                state_next = (top_reg >= rd_data.start) ? sist_pkg::ST_ABS : sist_pkg::ST_AFIX;
            sist_pkg::ST_AFIX: state_next = sist_pkg::ST_COMP;
            sist_pkg::ST_RSCAN:
                state_next = (j_reg < count_reg) ? sist_pkg::ST_RSCAN_CMP : sist_pkg::ST_COMP;
            sist_pkg::ST_RSCAN_CMP: begin
                if (rd_data.start < e_reg && rd_data.stop <= e_reg) begin
                    state_next = sist_pkg::ST_RSCAN;
                end else begin
                    state_next = sist_pkg::ST_COMP;
                end
            end
            sist_pkg::ST_COMP: begin
                if (comp_done) begin
                    state_next = fix_reg ? sist_pkg::ST_FIXPREV : sist_pkg::ST_FINISH;
                end else begin
                    state_next = sist_pkg::ST_COMP_W;
                end
            end
            sist_pkg::ST_COMP_W: state_next = sist_pkg::ST_COMP;
            sist_pkg::ST_FIXPREV:
                state_next = (prev_cut && e_reg < prev_reg.stop) ? sist_pkg::ST_SHUP
                                                                 : sist_pkg::ST_FINISH;
            sist_pkg::ST_SHUP:
                state_next = (j_reg > pos_reg) ? sist_pkg::ST_SHUP_W : sist_pkg::ST_FINISH;
            sist_pkg::ST_SHUP_W: state_next = sist_pkg::ST_SHUP;
            sist_pkg::ST_FINISH:
                if (res_ready) begin
                    state_next = sist_pkg::ST_IDLE;
                end
            default: state_next = sist_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        cmd_next      = cmd_reg;
        s_next        = s_reg;
        e_next        = e_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        p_next        = p_reg;
        pos_next      = pos_reg;
        j_next        = j_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        prev_next     = prev_reg;
        nxt_next      = nxt_reg;
        ins_next      = ins_reg;
        has_prev_next = has_prev_reg;
        has_next_next = has_next_reg;
        fix_next      = fix_reg;
        nstart_next   = nstart_reg;
        top_next      = top_reg;
        answer_next   = answer_reg;
        status_next   = status_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = ins_reg;
        in_ready      = (state_reg == sist_pkg::ST_IDLE);
        res_valid     = (state_reg == sist_pkg::ST_FINISH);
        res.answer       = answer_reg;
        res.status       = status_reg;
        res.entries_used = 7'(count_reg);

        case (state_reg)
            // take the command, settle empty and reversed ranges at once
            sist_pkg::ST_IDLE: begin
                cmd_next    = in_cmd;
                s_next      = in_start;
                e_next      = in_end;
                lo_next     = '0;
                hi_next     = count_reg;
                answer_next = (in_end == in_start) && (in_cmd == sist_pkg::CMD_CONTAINS);
                status_next = (in_end < in_start) ? sist_pkg::STATUS_RANGE
                                                  : sist_pkg::STATUS_OK;
            end
            // lower bound on start
            sist_pkg::ST_SRCH: begin
                mid_next = mid_sum[CW:1];
                p_next   = lo_reg;
                rd_en    = (lo_reg < hi_reg);
                rd_addr  = mid_sum[IW:1];
            end
            sist_pkg::ST_SRCH_CMP: begin
                if (rd_data.start < s_reg) begin
                    lo_next = mid_reg + ONE;
                end else begin
                    hi_next = mid_reg;
                end
            end
            // fetch the neighbours around the search point
            sist_pkg::ST_PREV: begin
                has_prev_next = (p_reg != '0);
                rd_en         = (p_reg != '0);
                rd_addr       = IW'(p_reg - ONE);
            end
            sist_pkg::ST_PREV_W: prev_next = rd_data;
            sist_pkg::ST_NEXT: begin
                has_next_next = (p_reg < count_reg);
                rd_en         = (p_reg < count_reg);
                rd_addr       = p_reg[IW-1:0];
            end
            sist_pkg::ST_NEXT_W: nxt_next = rd_data;
            sist_pkg::ST_DECIDE: begin
                case (cmd_reg)
                    sist_pkg::CMD_ADD: begin
                        if (add_left) begin
                            pos_next    = p_reg - ONE;
                            nstart_next = prev_reg.start;
                            top_next    = (prev_reg.stop < e_reg) ? e_reg : prev_reg.stop;
                            j_next      = p_reg;
                        end else if (add_right) begin
                            pos_next    = p_reg;
                            nstart_next = s_reg;
                            top_next    = (nxt_reg.stop < e_reg) ? e_reg : nxt_reg.stop;
                            j_next      = p_reg + ONE;
                        end else if (count_reg >= CAP) begin
                            status_next = sist_pkg::STATUS_FULL;
                        end else begin
                            pos_next       = p_reg;
                            j_next         = count_reg;
                            ins_next.start = s_reg;
                            ins_next.stop  = e_reg;
                        end
                    end
                    sist_pkg::CMD_REMOVE: begin
                        if (rem_full) begin
                            status_next = sist_pkg::STATUS_FULL;
                        end
                        j_next   = p_reg;
                        fix_next = 1'b1;
                    end
                    sist_pkg::CMD_INTERSECTS: begin
                        answer_next = (has_prev_reg && prev_reg.stop > s_reg) ||
                                      (has_next_reg && nxt_reg.start < e_reg);
                    end
                    default: begin
                        if (has_next_reg && nxt_reg.start == s_reg) begin
                            answer_next = (nxt_reg.stop >= e_reg);
                        end else begin
                            answer_next = has_prev_reg && (prev_reg.stop >= e_reg) &&
                                          (prev_reg.start <= s_reg);
                        end
                    end
                endcase
            end
            // absorb following entries that the merged interval reaches
            sist_pkg::ST_ABS: begin
                rd_en   = (j_reg < count_reg);
                rd_addr = j_reg[IW-1:0];
            end
            sist_pkg::ST_ABS_CMP: begin
                if (top_reg >= rd_data.start) begin
                    if (rd_data.stop > top_reg) begin
                        top_next = rd_data.stop;
                    end
                    j_next = j_reg + ONE;
                end
            end
            sist_pkg::ST_AFIX: begin
                wr_en         = 1'b1;
                wr_addr       = pos_reg[IW-1:0];
                wr_data.start = nstart_reg;
                wr_data.stop  = top_reg;
                src_next      = j_reg;
                dst_next      = pos_reg + ONE;
                fix_next      = 1'b0;
            end
            // drop covered entries, trim the first one that reaches past end
            sist_pkg::ST_RSCAN: begin
                rd_en    = (j_reg < count_reg);
                rd_addr  = j_reg[IW-1:0];
                src_next = j_reg;
                dst_next = p_reg;
            end
            sist_pkg::ST_RSCAN_CMP: begin
                src_next = j_reg;
                dst_next = p_reg;
                if (rd_data.start < e_reg) begin
                    if (rd_data.stop <= e_reg) begin
                        j_next = j_reg + ONE;
                    end else begin
                        wr_en         = 1'b1;
                        wr_addr       = j_reg[IW-1:0];
                        wr_data.start = e_reg;
                        wr_data.stop  = rd_data.stop;
                    end
                end
            end
            // close the gap left by dropped entries
            sist_pkg::ST_COMP: begin
                if (comp_done) begin
                    count_next = count_reg - (src_reg - dst_reg);
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = src_reg[IW-1:0];
                end
            end
            sist_pkg::ST_COMP_W: begin
                wr_en    = 1'b1;
                wr_addr  = dst_reg[IW-1:0];
                wr_data  = rd_data;
                src_next = src_reg + ONE;
                dst_next = dst_reg + ONE;
            end
            // cut the entry in front of the range, split it if needed
            sist_pkg::ST_FIXPREV: begin
                if (prev_cut) begin
                    wr_en          = 1'b1;
                    wr_addr        = IW'(p_reg - ONE);
                    wr_data.start  = prev_reg.start;
                    wr_data.stop   = s_reg;
                    ins_next.start = e_reg;
                    ins_next.stop  = prev_reg.stop;
                    pos_next       = p_reg;
                    j_next         = count_reg;
                end
            end
            // open a slot by moving entries up, then place the new one
            sist_pkg::ST_SHUP: begin
                if (j_reg > pos_reg) begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(j_reg - ONE);
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[IW-1:0];
                    wr_data    = ins_reg;
                    count_next = count_reg + ONE;
                end
            end
            sist_pkg::ST_SHUP_W: begin
                wr_en   = 1'b1;
                wr_addr = j_reg[IW-1:0];
                wr_data = rd_data;
                j_next  = j_reg - ONE;
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/core/sorted_interval_set_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_interval_set_table
// Sorted table of disjoint half-open 32-bit intervals with add, remove and
// query commands over stream channels.
// ----------------------------------------------------------------------------
// One command is handled at a time; s_tready is low while it runs. A query
// is bounded by the binary search through the single registered read port
// of the store. Add and remove then also step through every entry merged,
// dropped or moved: absorbing reads each entry that it reaches, and the
// compaction after a drop and the upward shift for an insert or split each
// read and then write one entry at a time. Empty and reversed ranges skip
// the search and go straight to the result. The result waits in its own
// output register, so the next command may be accepted before it is taken.
module sorted_interval_set_table #(
    parameter int TABLE_CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // range_start[31:0], range_end[63:32]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // answer[0], status[2:1], entries_used[9:3]
);

    localparam int IW = $clog2(TABLE_CAPACITY);

    logic                wr_en, rd_en;
    logic [IW-1:0]       wr_addr, rd_addr;
    sist_pkg::entry_t    wr_data, rd_data;
    logic                res_valid, res_ready;
    sist_pkg::result_t   res;
    logic                m_valid_reg, m_valid_next;
    logic [15:0]         m_data_reg, m_data_next;

    sist_seq #(
        .TABLE_CAPACITY(TABLE_CAPACITY)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (sist_pkg::cmd_t'(s_tuser)),
        .in_start  (s_tdata[31:0]),
        .in_end    (s_tdata[63:32]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    sist_table_mem #(
        .TABLE_CAPACITY(TABLE_CAPACITY)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // load a finished result when the output register is free or draining
    always_comb begin
        res_ready    = !m_valid_reg || m_tready;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = {6'b0, res};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // hold the result transaction until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
